@@ src/csl_pkg.sv @@
//------------------------------------------------------------------------------
// csl_pkg: shared types and constants for the C subset lexer
// Automaton states, directive phases, token classes, error kinds and the
// record that travels from the lexer front end to the output queue.
//------------------------------------------------------------------------------
`default_nettype none
package csl_pkg;

    localparam int OFFSET_WIDTH_DEF = 24;
    localparam int LENGTH_WIDTH_DEF = 8;
    localparam int LINE_WIDTH_DEF   = 16;
    localparam int ERR_WIDTH        = 16;
    localparam int NUM_KW           = 15;

    typedef enum logic [4:0] {
        ST_START   = 5'd0,  ST_WORD    = 5'd1,  ST_ZERO    = 5'd2,  ST_DIGITS  = 5'd3,
        ST_HEXPFX  = 5'd4,  ST_HEXDIG  = 5'd5,  ST_FRAC    = 5'd6,  ST_EXPMARK = 5'd7,
        ST_EXPDIG  = 5'd8,  ST_LEAD    = 5'd9,  ST_POINT   = 5'd10, ST_CHOPEN  = 5'd11,
        ST_CHESC   = 5'd12, ST_CHCLOSE = 5'd13, ST_GT      = 5'd14, ST_LT      = 5'd15,
        ST_EQ      = 5'd16, ST_BANG    = 5'd17, ST_AMP     = 5'd18, ST_BAR     = 5'd19,
        ST_PLUS    = 5'd20, ST_MINUS   = 5'd21, ST_STAR    = 5'd22, ST_SLASH   = 5'd23,
        ST_PCT     = 5'd24
    } lex_state_t;

    typedef enum logic [2:0] {
        DP_IDLE = 3'd0, DP_PRE = 3'd1, DP_HEAD = 3'd2, DP_SEEK = 3'd3, DP_NAME = 3'd4
    } dir_phase_t;

    localparam logic [5:0] CL_ERR     = 6'd0;
    localparam logic [5:0] CL_IDENT   = 6'd16;
    localparam logic [5:0] CL_INT     = 6'd17;
    localparam logic [5:0] CL_LONG    = 6'd18;
    localparam logic [5:0] CL_FLOAT   = 6'd19;
    localparam logic [5:0] CL_CHAR    = 6'd20;
    localparam logic [5:0] CL_LPAREN  = 6'd21;
    localparam logic [5:0] CL_RPAREN  = 6'd22;
    localparam logic [5:0] CL_LBRACK  = 6'd23;
    localparam logic [5:0] CL_RBRACK  = 6'd24;
    localparam logic [5:0] CL_LBRACE  = 6'd25;
    localparam logic [5:0] CL_RBRACE  = 6'd26;
    localparam logic [5:0] CL_SEMI    = 6'd40;
    localparam logic [5:0] CL_COMMA   = 6'd41;
    localparam logic [5:0] CL_INCLUDE = 6'd48;
    localparam logic [5:0] CL_END     = 6'd49;

    localparam logic [2:0] EK_NONE    = 3'd0;
    localparam logic [2:0] EK_ILLEGAL = 3'd1;
    localparam logic [2:0] EK_HEX     = 3'd2;
    localparam logic [2:0] EK_EXP     = 3'd3;
    localparam logic [2:0] EK_FLOAT   = 3'd4;
    localparam logic [2:0] EK_CHAR    = 3'd5;
    localparam logic [2:0] EK_OP      = 3'd6;
    localparam logic [2:0] EK_DIR     = 3'd7;

    // character of keyword k at position p, 0 past its end
    function automatic logic [7:0] kw_char(input int k, input int p);
        string s;
        case (k)
            0: s = "void";     1: s = "int";   2: s = "char";  3: s = "short";
            4: s = "long";     5: s = "double"; 6: s = "float"; 7: s = "const";
            8: s = "while";    9: s = "for";   10: s = "continue"; 11: s = "break";
            12: s = "if";      13: s = "else"; default: s = "return";
        endcase
        if (p < s.len()) return s[p];
        return 8'd0;
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        case (k)
            0: return 4'd4;  1: return 4'd3;  2: return 4'd4;  3: return 4'd5;
            4: return 4'd4;  5: return 4'd6;  6: return 4'd5;  7: return 4'd5;
            8: return 4'd5;  9: return 4'd3;  10: return 4'd8; 11: return 4'd5;
            12: return 4'd2; 13: return 4'd4; default: return 4'd6;
        endcase
    endfunction

    function automatic logic [7:0] dir_char(input logic inc, input int p);
        string s;
        s = inc ? "include" : "define";
        if (p < s.len()) return s[p];
        return 8'd0;
    endfunction

endpackage
`default_nettype wire

@@ src/csl_front.sv @@
//------------------------------------------------------------------------------
// csl_front: lexer automaton
// Runs the automaton on one byte a cycle while step is high and produces up to two results.
//------------------------------------------------------------------------------
`default_nettype none
module csl_front #(
    parameter int OFFSET_WIDTH = csl_pkg::OFFSET_WIDTH_DEF,
    parameter int LENGTH_WIDTH = csl_pkg::LENGTH_WIDTH_DEF,
    parameter int LINE_WIDTH   = csl_pkg::LINE_WIDTH_DEF,
    parameter int RW           = 6 + 3 + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH
                                 + csl_pkg::ERR_WIDTH + 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire logic [7:0]    char_byte,
    input  wire logic          eoi,
    output logic [1:0]         res_count,
    output logic [RW-1:0]      res0,
    output logic [RW-1:0]      res1
);
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
    localparam logic [csl_pkg::ERR_WIDTH-1:0] ERR_MAX = '1;

    csl_pkg::lex_state_t        st_reg, st_next;
    csl_pkg::dir_phase_t        dp_reg, dp_next;
    logic [1:0]                 dm_reg, dm_next;
    logic                       skip_reg, skip_next;
    logic [csl_pkg::NUM_KW-1:0] kw_reg, kw_next;
    logic [OFFSET_WIDTH-1:0]    ps_reg, ps_next;
    logic [LENGTH_WIDTH-1:0]    pl_reg, pl_next;
    logic [OFFSET_WIDTH-1:0]    off_reg, off_next;
    logic [LINE_WIDTH-1:0]      line_reg, line_next;
    logic [csl_pkg::ERR_WIDTH-1:0] err_reg, err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= csl_pkg::ST_START;
            dp_reg   <= csl_pkg::DP_IDLE;
            dm_reg   <= 2'b11;
            skip_reg <= 1'b0;
            kw_reg   <= '1;
            ps_reg   <= '0;
            pl_reg   <= '0;
            off_reg  <= '0;
            line_reg <= LINE_WIDTH'(1);
            err_reg  <= '0;
        end else if (step) begin
            st_reg   <= st_next;
            dp_reg   <= dp_next;
            dm_reg   <= dm_next;
            skip_reg <= skip_next;
            kw_reg   <= kw_next;
            ps_reg   <= ps_next;
            pl_reg   <= pl_next;
            off_reg  <= off_next;
            line_reg <= line_next;
            err_reg  <= err_next;
        end
    end

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // Pass-local working variables; up to four passes over the same byte
    always_comb begin
        csl_pkg::lex_state_t st;
        csl_pkg::dir_phase_t dp;
        logic [1:0]  dm;
        logic        skip;
        logic [csl_pkg::NUM_KW-1:0] kw;
        logic [OFFSET_WIDTH-1:0] ps;
        logic [LENGTH_WIDTH-1:0] pl;
        logic [LINE_WIDTH-1:0]   line;
        logic [csl_pkg::ERR_WIDTH-1:0] err;
        logic        again, blank, stop, isend;
        logic [1:0]  n;
        logic [5:0]  cls [2];
        logic [2:0]  ek [2];
        logic [OFFSET_WIDTH-1:0] rs [2];
        logic [LENGTH_WIDTH-1:0] rl [2];
        logic [LINE_WIDTH-1:0]   rln [2];
        logic [csl_pkg::ERR_WIDTH-1:0] re [2];
        logic [5:0]  ecls;
        logic [2:0]  eek;
        logic [OFFSET_WIDTH-1:0] est;
        logic [LENGTH_WIDTH-1:0] elen;
        logic        do_emit, do_fail;
        logic [2:0]  fkind;
        logic [7:0]  c;
        logic [7:0]  sec;
        logic [5:0]  pair, single;

        st = st_reg; dp = dp_reg; dm = dm_reg; skip = skip_reg; kw = kw_reg;
        ps = ps_reg; pl = pl_reg; line = line_reg; err = err_reg;
        n = 2'd0;
        c = char_byte;
        isend = eoi;
        blank = !isend && (c == " " || c == "\t" || c == "\r");
        stop = blank || isend || c == "\n";
        for (int i = 0; i < 2; i++) begin
            cls[i] = '0; ek[i] = '0; rs[i] = '0; rl[i] = '0; rln[i] = '0; re[i] = '0;
        end
        again = 1'b1;
        for (int pass = 0; pass < 4; pass++) begin
            do_emit = 1'b0; do_fail = 1'b0; fkind = csl_pkg::EK_NONE;
            ecls = '0; eek = '0; est = '0; elen = '0;
            sec = 8'd0; pair = '0; single = '0;
            if (again) begin
                again = 1'b0;
                if (skip) begin
                    if (!isend && c == "\n") begin
                        skip = 1'b0; again = 1'b1;
                    end
                end else if (dp != csl_pkg::DP_IDLE) begin
                    case (dp)
                        csl_pkg::DP_PRE: begin
                            if (blank) begin
                            end else if (stop) begin
                                do_fail = 1'b1; fkind = csl_pkg::EK_DIR;
                            end else begin
                                dp = csl_pkg::DP_HEAD;
                                if (csl_pkg::dir_char(1'b0, 0) != c) dm[0] = 1'b0;
                                if (csl_pkg::dir_char(1'b1, 0) != c) dm[1] = 1'b0;
                                if (dm == 2'b00) begin
                                    do_fail = 1'b1; fkind = csl_pkg::EK_DIR;
                                end else pl = LENGTH_WIDTH'(1);
                            end
                        end
                        csl_pkg::DP_HEAD: begin
                            if (!stop) begin
                                if (!(pl < 6 && csl_pkg::dir_char(1'b0, int'(pl)) == c))
                                    dm[0] = 1'b0;
                                if (!(pl < 7 && csl_pkg::dir_char(1'b1, int'(pl)) == c))
                                    dm[1] = 1'b0;
                                if (dm == 2'b00) begin
                                    do_fail = 1'b1; fkind = csl_pkg::EK_DIR;
                                end else if (pl != LEN_MAX) pl = pl + 1'b1;
                            end else if (dm[0] && pl == LENGTH_WIDTH'(6)) begin
                                dp = csl_pkg::DP_IDLE; pl = '0; skip = 1'b1; again = 1'b1;
                            end else if (dm[1] && pl == LENGTH_WIDTH'(7)) begin
                                dp = csl_pkg::DP_SEEK; again = 1'b1;
                            end else begin
                                do_fail = 1'b1; fkind = csl_pkg::EK_DIR;
                            end
                        end
                        csl_pkg::DP_SEEK: begin
                            if (!isend && c == "\"") begin
                                dp = csl_pkg::DP_NAME; ps = off_reg + 1'b1; pl = '0;
                            end else if (isend || c == "\n") begin
                                do_fail = 1'b1; fkind = csl_pkg::EK_DIR;
                            end
                        end
                        csl_pkg::DP_NAME: begin
                            if (!isend && c == "\"") begin
                                do_emit = 1'b1; ecls = csl_pkg::CL_INCLUDE;
                                est = ps; elen = pl;
                                dp = csl_pkg::DP_IDLE; pl = '0; skip = 1'b1;
                            end else if (isend || c == "\n" || c == "\r") begin
                                do_fail = 1'b1; fkind = csl_pkg::EK_DIR;
                            end else if (pl != LEN_MAX) pl = pl + 1'b1;
                        end
                        default: begin
                            dp = csl_pkg::DP_IDLE; again = 1'b1;
                        end
                    endcase
                end else begin
                    case (st)
                        csl_pkg::ST_START: begin
                            if (isend || c == " " || c == "\t" || c == "\r") begin
                            end else if (is_alpha(c) || c == "_") begin
                                st = csl_pkg::ST_WORD; ps = off_reg; pl = LENGTH_WIDTH'(1);
                                for (int k = 0; k < csl_pkg::NUM_KW; k++)
                                    kw[k] = (csl_pkg::kw_char(k, 0) == c);
                            end else if (c == "\n") begin
                                if (line != LINE_MAX) line = line + 1'b1;
                            end else if (c == "#") begin
                                dp = csl_pkg::DP_PRE; dm = 2'b11; pl = '0;
                            end else if (c == "(" || c == ")" || c == "[" || c == "]" ||
                                         c == "{" || c == "}" || c == ";" || c == ",") begin
                                do_emit = 1'b1; est = off_reg; elen = LENGTH_WIDTH'(1);
                                case (c)
                                    "(": ecls = csl_pkg::CL_LPAREN;
                                    ")": ecls = csl_pkg::CL_RPAREN;
                                    "[": ecls = csl_pkg::CL_LBRACK;
                                    "]": ecls = csl_pkg::CL_RBRACK;
                                    "{": ecls = csl_pkg::CL_LBRACE;
                                    "}": ecls = csl_pkg::CL_RBRACE;
                                    ";": ecls = csl_pkg::CL_SEMI;
                                    default: ecls = csl_pkg::CL_COMMA;
                                endcase
                            end else begin
                                ps = off_reg; pl = LENGTH_WIDTH'(1);
                                case (c)
                                    "0": st = csl_pkg::ST_ZERO;
                                    ".": st = csl_pkg::ST_POINT;
                                    "'": st = csl_pkg::ST_CHOPEN;
                                    ">": st = csl_pkg::ST_GT;
                                    "<": st = csl_pkg::ST_LT;
                                    "=": st = csl_pkg::ST_EQ;
                                    "!": st = csl_pkg::ST_BANG;
                                    "&": st = csl_pkg::ST_AMP;
                                    "|": st = csl_pkg::ST_BAR;
                                    "+": st = csl_pkg::ST_PLUS;
                                    "-": st = csl_pkg::ST_MINUS;
                                    "*": st = csl_pkg::ST_STAR;
                                    "/": st = csl_pkg::ST_SLASH;
                                    "%": st = csl_pkg::ST_PCT;
                                    default: begin
                                        if (c >= "1" && c <= "9") st = csl_pkg::ST_LEAD;
                                        else begin
                                            pl = pl_reg;
                                            do_fail = 1'b1; fkind = csl_pkg::EK_ILLEGAL;
                                        end
                                    end
                                endcase
                            end
                        end
                        csl_pkg::ST_WORD: begin
                            if (!isend && (is_alpha(c) || c == "_" || is_digit(c))) begin
                                for (int k = 0; k < csl_pkg::NUM_KW; k++)
                                    if (csl_pkg::kw_char(k, int'(pl)) != c || pl >= 8)
                                        kw[k] = 1'b0;
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                            end else begin
                                do_emit = 1'b1; ecls = csl_pkg::CL_IDENT;
                                for (int k = 0; k < csl_pkg::NUM_KW; k++)
                                    if (kw[k] && LENGTH_WIDTH'(csl_pkg::kw_len(k)) == pl)
                                        ecls = 6'(k + 1);
                                est = ps; elen = pl; st = csl_pkg::ST_START; pl = '0;
                                again = 1'b1;
                            end
                        end
                        csl_pkg::ST_ZERO, csl_pkg::ST_LEAD, csl_pkg::ST_DIGITS,
                        csl_pkg::ST_HEXDIG: begin
                            if (!isend && st != csl_pkg::ST_HEXDIG && is_digit(c)) begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                st = csl_pkg::ST_DIGITS;
                            end else if (!isend && st == csl_pkg::ST_HEXDIG && is_hex(c)) begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                            end else if (!isend && st == csl_pkg::ST_ZERO &&
                                         (c == "x" || c == "X")) begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                st = csl_pkg::ST_HEXPFX;
                            end else if (!isend && st != csl_pkg::ST_HEXDIG && c == ".") begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                st = csl_pkg::ST_FRAC;
                            end else if (!isend && st != csl_pkg::ST_HEXDIG &&
                                         (c == "e" || c == "E")) begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                st = csl_pkg::ST_EXPMARK;
                            end else if (!isend && c == "L") begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                do_emit = 1'b1; ecls = csl_pkg::CL_LONG; est = ps; elen = pl;
                                st = csl_pkg::ST_START; pl = '0;
                            end else begin
                                do_emit = 1'b1; ecls = csl_pkg::CL_INT; est = ps; elen = pl;
                                st = csl_pkg::ST_START; pl = '0; again = 1'b1;
                            end
                        end
                        csl_pkg::ST_HEXPFX, csl_pkg::ST_EXPMARK, csl_pkg::ST_POINT: begin
                            if (!isend && st == csl_pkg::ST_HEXPFX && is_hex(c)) begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                st = csl_pkg::ST_HEXDIG;
                            end else if (!isend && st != csl_pkg::ST_HEXPFX && is_digit(c)) begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                st = (st == csl_pkg::ST_POINT) ? csl_pkg::ST_FRAC
                                                               : csl_pkg::ST_EXPDIG;
                            end else begin
                                do_fail = 1'b1;
                                fkind = (st == csl_pkg::ST_HEXPFX) ? csl_pkg::EK_HEX :
                                        (st == csl_pkg::ST_EXPMARK) ? csl_pkg::EK_EXP
                                                                    : csl_pkg::EK_FLOAT;
                            end
                        end
                        csl_pkg::ST_FRAC, csl_pkg::ST_EXPDIG: begin
                            if (!isend && is_digit(c)) begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                            end else if (!isend && st == csl_pkg::ST_FRAC &&
                                         (c == "e" || c == "E")) begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                st = csl_pkg::ST_EXPMARK;
                            end else begin
                                do_emit = 1'b1; ecls = csl_pkg::CL_FLOAT; est = ps; elen = pl;
                                st = csl_pkg::ST_START; pl = '0; again = 1'b1;
                            end
                        end
                        csl_pkg::ST_CHOPEN, csl_pkg::ST_CHESC: begin
                            if (isend || c == "\n") begin
                                do_fail = 1'b1; fkind = csl_pkg::EK_CHAR;
                            end else begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                st = (st == csl_pkg::ST_CHOPEN && c == "\\") ?
                                     csl_pkg::ST_CHESC : csl_pkg::ST_CHCLOSE;
                            end
                        end
                        csl_pkg::ST_CHCLOSE: begin
                            if (!isend && c == "'") begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                do_emit = 1'b1; ecls = csl_pkg::CL_CHAR; est = ps; elen = pl;
                                st = csl_pkg::ST_START; pl = '0;
                            end else begin
                                do_fail = 1'b1; fkind = csl_pkg::EK_CHAR;
                            end
                        end
                        csl_pkg::ST_GT, csl_pkg::ST_LT, csl_pkg::ST_EQ, csl_pkg::ST_BANG,
                        csl_pkg::ST_AMP, csl_pkg::ST_BAR, csl_pkg::ST_PLUS,
                        csl_pkg::ST_MINUS, csl_pkg::ST_STAR, csl_pkg::ST_SLASH,
                        csl_pkg::ST_PCT: begin
                            sec = "=";
                            case (st)
                                csl_pkg::ST_GT:    begin pair = 6'd33; single = 6'd32; end
                                csl_pkg::ST_LT:    begin pair = 6'd35; single = 6'd34; end
                                csl_pkg::ST_EQ:    begin pair = 6'd36; single = 6'd42; end
                                csl_pkg::ST_BANG:  begin pair = 6'd37; single = 6'd0;  end
                                csl_pkg::ST_AMP:   begin
                                    pair = 6'd38; single = 6'd0; sec = "&";
                                end
                                csl_pkg::ST_BAR:   begin
                                    pair = 6'd39; single = 6'd0; sec = "|";
                                end
                                csl_pkg::ST_PLUS:  begin pair = 6'd43; single = 6'd27; end
                                csl_pkg::ST_MINUS: begin pair = 6'd44; single = 6'd28; end
                                csl_pkg::ST_STAR:  begin pair = 6'd45; single = 6'd29; end
                                csl_pkg::ST_SLASH: begin pair = 6'd46; single = 6'd30; end
                                default:           begin pair = 6'd47; single = 6'd31; end
                            endcase
                            if (!isend && c == sec) begin
                                if (pl != LEN_MAX) pl = pl + 1'b1;
                                do_emit = 1'b1; ecls = pair; est = ps; elen = pl;
                                st = csl_pkg::ST_START; pl = '0;
                            end else if (single == 6'd0) begin
                                do_fail = 1'b1; fkind = csl_pkg::EK_OP;
                            end else begin
                                do_emit = 1'b1; ecls = single; est = ps; elen = pl;
                                st = csl_pkg::ST_START; pl = '0; again = 1'b1;
                            end
                        end
                        default: begin
                            st = csl_pkg::ST_START; again = 1'b1;
                        end
                    endcase
                end
                if (do_fail) begin
                    if (err != ERR_MAX) err = err + 1'b1;
                    do_emit = 1'b1; ecls = csl_pkg::CL_ERR; eek = fkind;
                    est = off_reg; elen = isend ? '0 : LENGTH_WIDTH'(1);
                    st = csl_pkg::ST_START; dp = csl_pkg::DP_IDLE; pl = '0; skip = 1'b1;
                    again = 1'b1;
                end
                if (do_emit && n != 2'd2) begin
                    cls[n[0]] = ecls; ek[n[0]] = eek; rs[n[0]] = est; rl[n[0]] = elen;
                    rln[n[0]] = line; re[n[0]] = err;
                    n = n + 1'b1;
                end
            end
        end
        if (isend) begin
            if (n != 2'd2) begin
                cls[n[0]] = csl_pkg::CL_END; ek[n[0]] = csl_pkg::EK_NONE;
                rs[n[0]] = off_reg; rl[n[0]] = '0; rln[n[0]] = line; re[n[0]] = err;
                n = n + 1'b1;
            end
            st = csl_pkg::ST_START; dp = csl_pkg::DP_IDLE; dm = 2'b11; skip = 1'b0;
            kw = '1; pl = '0;
            off_next = off_reg;
        end else begin
            off_next = off_reg + 1'b1;
        end
        st_next = st; dp_next = dp; dm_next = dm; skip_next = skip; kw_next = kw;
        ps_next = ps; pl_next = pl; line_next = line; err_next = err;
        res_count = n;
        res0 = {(n == 2'd1), re[0], rln[0], rl[0], rs[0], ek[0], cls[0]};
        res1 = {1'b1, re[1], rln[1], rl[1], rs[1], ek[1], cls[1]};
    end
endmodule
`default_nettype wire

@@ src/csl_queue.sv @@
//------------------------------------------------------------------------------
// csl_queue: result queue
// Four-entry FIFO that takes up to two results a cycle and gives one while rd_ready is high.
//------------------------------------------------------------------------------
`default_nettype none
module csl_queue #(
    parameter int RW = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_en,
    input  wire logic [1:0]    wr_count,
    input  wire logic [RW-1:0] wr_data0,
    input  wire logic [RW-1:0] wr_data1,
    output logic               space2,
    output logic               rd_valid,
    output logic [RW-1:0]      rd_data,
    input  wire logic          rd_ready
);
    logic [RW-1:0] mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic [1:0] wadd;
    logic       pop;

    assign wadd     = wr_en ? wr_count : 2'd0;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign pop      = rd_valid && rd_ready;
    assign space2   = cnt_reg <= 3'd2;

    always_ff @(posedge aclk) begin
        if (wadd != 2'd0) mem_reg[wp_reg] <= wr_data0;
        if (wadd == 2'd2) mem_reg[wp_reg + 2'd1] <= wr_data1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg + wadd;
            rp_reg  <= rp_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, wadd} - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

@@ src/c_subset_lexer.sv @@
//------------------------------------------------------------------------------
// c_subset_lexer: byte-serial lexer for a C subset
// Automaton front end feeding a small result queue toward the token stream.
//------------------------------------------------------------------------------
// Usage:
//   s_axis: one source byte per transaction in s_axis_tdata[7:0];
//           s_axis_tuser = 1 marks end of input (the byte is ignored).
//   m_axis: one token per transaction; m_axis_tlast marks the last token
//           caused by an input byte. Each byte gives zero, one or two tokens.
// Throughput: one byte per cycle while the queue has room; the whole automaton
//   step, including the re-scan of a token-ending byte, is one combinational pass.
// Timing: each token is registered in the result queue as its byte is accepted.
// The front end stalls only when the four-entry result queue has fewer than
//   two free slots, so a stalled receiver backs up into s_axis_tready once
//   more than two tokens are pending.
// Reset (aresetn low, synchronous): automaton to start, line 1, offset and
//   error count zero, queue empty.
//------------------------------------------------------------------------------
`default_nettype none
module c_subset_lexer #(
    parameter int OFFSET_WIDTH = csl_pkg::OFFSET_WIDTH_DEF,
    parameter int LENGTH_WIDTH = csl_pkg::LENGTH_WIDTH_DEF,
    parameter int LINE_WIDTH   = csl_pkg::LINE_WIDTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // char_byte
    input  wire logic       s_axis_tuser,   // end_of_input
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    // token_class, error_kind, token_start, token_length, line_number,
    // error_total, zero padded to bytes
    output logic [((6 + 3 + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH + 16 + 7) / 8) * 8 - 1:0]
                            m_axis_tdata,
    output logic            m_axis_tlast    // last_of_run
);
    localparam int PW = 6 + 3 + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH + 16;
    localparam int RW = PW + 1;
    localparam int DW = ((PW + 7) / 8) * 8;

    logic [1:0]    cnt;
    logic [RW-1:0] r0, r1, q;
    logic          space2, step;

    assign s_axis_tready = space2;
    assign step = s_axis_tvalid && space2;

    csl_front #(
        .OFFSET_WIDTH(OFFSET_WIDTH), .LENGTH_WIDTH(LENGTH_WIDTH),
        .LINE_WIDTH(LINE_WIDTH), .RW(RW)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .char_byte(s_axis_tdata), .eoi(s_axis_tuser),
        .res_count(cnt), .res0(r0), .res1(r1)
    );

    csl_queue #(.RW(RW)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_en(step), .wr_count(cnt),
        .wr_data0(r0), .wr_data1(r1), .space2(space2),
        .rd_valid(m_axis_tvalid), .rd_data(q), .rd_ready(m_axis_tready)
    );

    assign m_axis_tdata = DW'(q[PW-1:0]);
    assign m_axis_tlast = q[RW-1];
endmodule
`default_nettype wire

@@ bench/c_subset_lexer_tb.sv @@
//------------------------------------------------------------------------------
// c_subset_lexer_tb: self-checking bench for the C subset lexer
// Feeds source bytes over the input stream, predicts every token with a
// behavioral copy of the lexer automaton and checks each token transaction,
// field by field and in order, with random stalls on both sides.
//------------------------------------------------------------------------------
`default_nettype none
module c_subset_lexer_tb;

    // operator classes that the package does not name
    localparam logic [5:0] CL_PLUS    = 6'd27;
    localparam logic [5:0] CL_MINUS   = 6'd28;
    localparam logic [5:0] CL_STAR    = 6'd29;
    localparam logic [5:0] CL_SLASH   = 6'd30;
    localparam logic [5:0] CL_PCT     = 6'd31;
    localparam logic [5:0] CL_GT      = 6'd32;
    localparam logic [5:0] CL_GE      = 6'd33;
    localparam logic [5:0] CL_LT      = 6'd34;
    localparam logic [5:0] CL_LE      = 6'd35;
    localparam logic [5:0] CL_EQEQ    = 6'd36;
    localparam logic [5:0] CL_NE      = 6'd37;
    localparam logic [5:0] CL_ANDAND  = 6'd38;
    localparam logic [5:0] CL_OROR    = 6'd39;
    localparam logic [5:0] CL_ASSIGN  = 6'd42;
    localparam logic [5:0] CL_PLUSEQ  = 6'd43;
    localparam logic [5:0] CL_MINUSEQ = 6'd44;
    localparam logic [5:0] CL_STAREQ  = 6'd45;
    localparam logic [5:0] CL_SLASHEQ = 6'd46;
    localparam logic [5:0] CL_PCTEQ   = 6'd47;

    localparam logic [8:0] END_MARK   = 9'h100;
    localparam int         DATA_W     = 80;
    localparam int         STALL_LIMIT = 5000;

    typedef struct packed {
        logic [5:0]  cls;
        logic [2:0]  kind;
        logic [23:0] start;
        logic [7:0]  len;
        logic [15:0] line;
        logic [15:0] errs;
        logic        last;
    } token_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'd0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;   // class, kind, start, length, line, errors
    logic              m_axis_tlast;

    c_subset_lexer uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    //--------------------------------------------------------------------------
    // Token predictor: a behavioral lexer with its own state
    //--------------------------------------------------------------------------
    csl_pkg::lex_state_t  lx_state  = csl_pkg::ST_START;
    csl_pkg::dir_phase_t  dir_phase = csl_pkg::DP_IDLE;
    logic [1:0]  dir_live  = 2'b11;     // bit 0 "define", bit 1 "include"
    logic        skip_line = 1'b0;
    logic [14:0] kw_live   = '1;
    logic [23:0] tok_start = '0;
    logic [7:0]  tok_len   = '0;
    logic [23:0] byte_pos  = '0;
    logic [15:0] line_no   = 16'd1;
    logic [15:0] err_cnt   = '0;

    string kw_words[15] = '{"void", "int", "char", "short", "long", "double", "float",
                            "const", "while", "for", "continue", "break", "if", "else",
                            "return"};
    string dir_words[2] = '{"define", "include"};

    // two-character operators, indexed by state minus ST_GT
    logic [7:0] op_second[11] = '{"=", "=", "=", "=", "&", "|", "=", "=", "=", "=", "="};
    logic [5:0] op_pair[11]   = '{CL_GE, CL_LE, CL_EQEQ, CL_NE, CL_ANDAND, CL_OROR,
                                  CL_PLUSEQ, CL_MINUSEQ, CL_STAREQ, CL_SLASHEQ, CL_PCTEQ};
    // CL_ERR here means the lone character is an operator error
    logic [5:0] op_single[11] = '{CL_GT, CL_LT, CL_ASSIGN, csl_pkg::CL_ERR, csl_pkg::CL_ERR,
                                  csl_pkg::CL_ERR, CL_PLUS, CL_MINUS, CL_STAR, CL_SLASH,
                                  CL_PCT};

    token_t step_tokens[$];      // tokens of the byte being predicted
    token_t expected_tokens[$];  // tokens still to come out of the lexer

    function automatic void put_token(logic [5:0] cls, logic [2:0] kind,
                                      logic [23:0] start, logic [7:0] len);
        token_t t;
        if (step_tokens.size() >= 2) return;
        t = '{cls, kind, start, len, line_no, err_cnt, 1'b0};
        step_tokens = {step_tokens, t};
    endfunction

    function automatic void grow();
        if (tok_len != 8'hFF) tok_len++;
    endfunction

    function automatic void open_tok(csl_pkg::lex_state_t st, logic [23:0] off);
        lx_state  = st;
        tok_start = off;
        tok_len   = 8'd1;
    endfunction

    function automatic void flush_tok(logic [5:0] cls);
        put_token(cls, csl_pkg::EK_NONE, tok_start, tok_len);
        lx_state = csl_pkg::ST_START;
        tok_len  = 8'd0;
    endfunction

    // lexical error: count it, report it, then skip to the end of the line
    function automatic bit raise_err(logic [2:0] kind, logic [8:0] c, logic [23:0] off);
        if (err_cnt != 16'hFFFF) err_cnt++;
        put_token(csl_pkg::CL_ERR, kind, off, (c == END_MARK) ? 8'd0 : 8'd1);
        lx_state  = csl_pkg::ST_START;
        dir_phase = csl_pkg::DP_IDLE;
        tok_len   = 8'd0;
        skip_line = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit is_alpha(logic [8:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [8:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hex(logic [8:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // narrow the keyword candidates by one character of a word
    function automatic void take_char(logic [8:0] c);
        int pos;
        pos = tok_len;
        for (int i = 0; i < 15; i++)
            if (pos >= kw_words[i].len() || kw_words[i][pos] != c) kw_live[i] = 1'b0;
        grow();
    endfunction

    function automatic void flush_word();
        logic [5:0] cls;
        cls = csl_pkg::CL_IDENT;
        for (int i = 0; i < 15; i++)
            if (kw_live[i] && kw_words[i].len() == tok_len) cls = 6'(i + 1);
        flush_tok(cls);
    endfunction

    function automatic bit finish_number(logic [8:0] c);
        if (c == "L") begin
            grow();
            flush_tok(csl_pkg::CL_LONG);
            return 1'b0;
        end
        flush_tok(csl_pkg::CL_INT);
        return 1'b1;
    endfunction

    function automatic bit start_token(logic [8:0] c, logic [23:0] off);
        if (is_alpha(c) || c == "_") begin
            lx_state  = csl_pkg::ST_WORD;
            tok_start = off;
            tok_len   = 8'd0;
            kw_live   = '1;
            take_char(c);
            return 1'b0;
        end
        if (c >= "1" && c <= "9") begin
            open_tok(csl_pkg::ST_LEAD, off);
            return 1'b0;
        end
        case (c)
            "0":  open_tok(csl_pkg::ST_ZERO, off);
            ".":  open_tok(csl_pkg::ST_POINT, off);
            "'":  open_tok(csl_pkg::ST_CHOPEN, off);
            "(":  put_token(csl_pkg::CL_LPAREN, csl_pkg::EK_NONE, off, 8'd1);
            ")":  put_token(csl_pkg::CL_RPAREN, csl_pkg::EK_NONE, off, 8'd1);
            "[":  put_token(csl_pkg::CL_LBRACK, csl_pkg::EK_NONE, off, 8'd1);
            "]":  put_token(csl_pkg::CL_RBRACK, csl_pkg::EK_NONE, off, 8'd1);
            "{":  put_token(csl_pkg::CL_LBRACE, csl_pkg::EK_NONE, off, 8'd1);
            "}":  put_token(csl_pkg::CL_RBRACE, csl_pkg::EK_NONE, off, 8'd1);
            ";":  put_token(csl_pkg::CL_SEMI, csl_pkg::EK_NONE, off, 8'd1);
            ",":  put_token(csl_pkg::CL_COMMA, csl_pkg::EK_NONE, off, 8'd1);
            ">":  open_tok(csl_pkg::ST_GT, off);
            "<":  open_tok(csl_pkg::ST_LT, off);
            "=":  open_tok(csl_pkg::ST_EQ, off);
            "!":  open_tok(csl_pkg::ST_BANG, off);
            "&":  open_tok(csl_pkg::ST_AMP, off);
            "|":  open_tok(csl_pkg::ST_BAR, off);
            "+":  open_tok(csl_pkg::ST_PLUS, off);
            "-":  open_tok(csl_pkg::ST_MINUS, off);
            "*":  open_tok(csl_pkg::ST_STAR, off);
            "/":  open_tok(csl_pkg::ST_SLASH, off);
            "%":  open_tok(csl_pkg::ST_PCT, off);
            " ", "\t", "\r", END_MARK: ;
            "\n": if (line_no != 16'hFFFF) line_no++;
            "#": begin
                dir_phase = csl_pkg::DP_PRE;
                dir_live  = 2'b11;
                tok_len   = 8'd0;
            end
            default: return raise_err(csl_pkg::EK_ILLEGAL, c, off);
        endcase
        return 1'b0;
    endfunction

    function automatic bit head_char(logic [8:0] c, logic [23:0] off);
        int pos;
        pos = tok_len;
        for (int w = 0; w < 2; w++)
            if (!(pos < dir_words[w].len() && dir_words[w][pos] == c)) dir_live[w] = 1'b0;
        if (dir_live == 2'b00) return raise_err(csl_pkg::EK_DIR, c, off);
        grow();
        return 1'b0;
    endfunction

    function automatic bit directive_step(logic [8:0] c, logic [23:0] off);
        bit blank, stop;
        blank = (c == " " || c == "\t" || c == "\r");
        stop  = blank || c == "\n" || c == END_MARK;
        case (dir_phase)
            csl_pkg::DP_PRE: begin
                if (blank) return 1'b0;
                if (stop) return raise_err(csl_pkg::EK_DIR, c, off);
                dir_phase = csl_pkg::DP_HEAD;
                tok_len   = 8'd0;
                return head_char(c, off);
            end
            csl_pkg::DP_HEAD: begin
                if (!stop) return head_char(c, off);
                if (dir_live[0] && tok_len == 8'd6) begin
                    dir_phase = csl_pkg::DP_IDLE;
                    tok_len   = 8'd0;
                    skip_line = 1'b1;
                    return 1'b1;
                end
                if (dir_live[1] && tok_len == 8'd7) begin
                    dir_phase = csl_pkg::DP_SEEK;
                    return 1'b1;
                end
                return raise_err(csl_pkg::EK_DIR, c, off);
            end
            csl_pkg::DP_SEEK: begin
                if (c == "\"") begin
                    dir_phase = csl_pkg::DP_NAME;
                    tok_start = off + 24'd1;
                    tok_len   = 8'd0;
                    return 1'b0;
                end
                if (c == "\n" || c == END_MARK) return raise_err(csl_pkg::EK_DIR, c, off);
                return 1'b0;
            end
            csl_pkg::DP_NAME: begin
                if (c == "\"") begin
                    put_token(csl_pkg::CL_INCLUDE, csl_pkg::EK_NONE, tok_start, tok_len);
                    dir_phase = csl_pkg::DP_IDLE;
                    tok_len   = 8'd0;
                    skip_line = 1'b1;
                    return 1'b0;
                end
                if (c == "\n" || c == "\r" || c == END_MARK)
                    return raise_err(csl_pkg::EK_DIR, c, off);
                grow();
                return 1'b0;
            end
            default: begin
                dir_phase = csl_pkg::DP_IDLE;
                return 1'b1;
            end
        endcase
    endfunction

    // one automaton pass; returns 1 when the byte must be scanned again
    function automatic bit lex_pass(logic [8:0] c, logic [23:0] off);
        int k;
        if (skip_line) begin
            if (c == "\n") begin
                skip_line = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (dir_phase != csl_pkg::DP_IDLE) return directive_step(c, off);
        case (lx_state)
            csl_pkg::ST_START: return start_token(c, off);
            csl_pkg::ST_WORD: begin
                if (is_alpha(c) || c == "_" || is_digit(c)) begin
                    take_char(c);
                    return 1'b0;
                end
                flush_word();
                return 1'b1;
            end
            csl_pkg::ST_ZERO, csl_pkg::ST_LEAD, csl_pkg::ST_DIGITS: begin
                if (is_digit(c)) begin
                    grow(); lx_state = csl_pkg::ST_DIGITS; return 1'b0;
                end
                if (lx_state == csl_pkg::ST_ZERO && (c == "x" || c == "X")) begin
                    grow(); lx_state = csl_pkg::ST_HEXPFX; return 1'b0;
                end
                if (c == ".") begin
                    grow(); lx_state = csl_pkg::ST_FRAC; return 1'b0;
                end
                if (c == "e" || c == "E") begin
                    grow(); lx_state = csl_pkg::ST_EXPMARK; return 1'b0;
                end
                return finish_number(c);
            end
            csl_pkg::ST_HEXPFX: begin
                if (is_hex(c)) begin
                    grow(); lx_state = csl_pkg::ST_HEXDIG; return 1'b0;
                end
                return raise_err(csl_pkg::EK_HEX, c, off);
            end
            csl_pkg::ST_HEXDIG: begin
                if (is_hex(c)) begin
                    grow(); return 1'b0;
                end
                return finish_number(c);
            end
            csl_pkg::ST_FRAC: begin
                if (is_digit(c)) begin
                    grow(); return 1'b0;
                end
                if (c == "e" || c == "E") begin
                    grow(); lx_state = csl_pkg::ST_EXPMARK; return 1'b0;
                end
                flush_tok(csl_pkg::CL_FLOAT);
                return 1'b1;
            end
            csl_pkg::ST_EXPMARK: begin
                if (is_digit(c)) begin
                    grow(); lx_state = csl_pkg::ST_EXPDIG; return 1'b0;
                end
                return raise_err(csl_pkg::EK_EXP, c, off);
            end
            csl_pkg::ST_EXPDIG: begin
                if (is_digit(c)) begin
                    grow(); return 1'b0;
                end
                flush_tok(csl_pkg::CL_FLOAT);
                return 1'b1;
            end
            csl_pkg::ST_POINT: begin
                if (is_digit(c)) begin
                    grow(); lx_state = csl_pkg::ST_FRAC; return 1'b0;
                end
                return raise_err(csl_pkg::EK_FLOAT, c, off);
            end
            csl_pkg::ST_CHOPEN, csl_pkg::ST_CHESC: begin
                if (c == "\n" || c == END_MARK) return raise_err(csl_pkg::EK_CHAR, c, off);
                grow();
                lx_state = (lx_state == csl_pkg::ST_CHOPEN && c == "\\") ?
                           csl_pkg::ST_CHESC : csl_pkg::ST_CHCLOSE;
                return 1'b0;
            end
            csl_pkg::ST_CHCLOSE: begin
                if (c == "'") begin
                    grow(); flush_tok(csl_pkg::CL_CHAR); return 1'b0;
                end
                return raise_err(csl_pkg::EK_CHAR, c, off);
            end
            default: begin
                k = int'(lx_state) - int'(csl_pkg::ST_GT);
                if (c == {1'b0, op_second[k]}) begin
                    grow();
                    flush_tok(op_pair[k]);
                    return 1'b0;
                end
                if (op_single[k] == csl_pkg::CL_ERR) return raise_err(csl_pkg::EK_OP, c, off);
                flush_tok(op_single[k]);
                return 1'b1;
            end
        endcase
    endfunction

    // predict the tokens of one accepted transaction and queue them
    function automatic void predict_tokens(logic [7:0] b, logic eoi);
        logic [8:0] c;
        c = eoi ? END_MARK : {1'b0, b};
        step_tokens.delete();
        for (int pass = 0; pass < 4; pass++)
            if (!lex_pass(c, byte_pos)) break;
        if (eoi) begin
            put_token(csl_pkg::CL_END, csl_pkg::EK_NONE, byte_pos, 8'd0);
            lx_state  = csl_pkg::ST_START;
            dir_phase = csl_pkg::DP_IDLE;
            dir_live  = 2'b11;
            skip_line = 1'b0;
            kw_live   = '1;
            tok_len   = 8'd0;
        end else begin
            byte_pos++;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        expected_tokens = {expected_tokens, step_tokens};
    endfunction

    //--------------------------------------------------------------------------
    // Token checker
    //--------------------------------------------------------------------------
    int   mismatches = 0;
    int   quiet_cycles = 0;
    bit   idle_on = 1'b1;
    int   stall_left = 0;

    always @(posedge aclk) begin
        token_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[5:0], m_axis_tdata[8:6], m_axis_tdata[32:9],
                    m_axis_tdata[40:33], m_axis_tdata[56:41], m_axis_tdata[72:57],
                    m_axis_tlast};
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: cls %0d kind %0d start %0d len %0d",
                             got.cls, got.kind, got.start, got.len);
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"token mismatch: expected cls %0d kind %0d start %0d ",
                                  "len %0d line %0d errs %0d last %0d, got cls %0d kind %0d ",
                                  "start %0d len %0d line %0d errs %0d last %0d"},
                                 want.cls, want.kind, want.start, want.len, want.line,
                                 want.errs, want.last, got.cls, got.kind, got.start,
                                 got.len, got.line, got.errs, got.last);
                end
            end
        end
    end

    // receiver: random stall bursts while idling is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("c_subset_lexer_tb NOT OK");
            $finish;
        end
    end

    //--------------------------------------------------------------------------
    // Stimulus
    //--------------------------------------------------------------------------
    // send one byte (or end mark); valid stays high across back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eoi;
        do @(posedge aclk); while (!s_axis_tready);
        predict_tokens(b, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_words();
        string big;
        send_text("void int char short long double float const while for continue\n");
        send_text("break if else return _x9 shorts in Z\n");
        big = "";
        repeat (300) big = {big, "a"};   // length saturates
        send_text({big, " "});
    endtask

    task automatic test_numbers();
        send_text("0 077 123L 0x1fL 0XaB 1.5 1.5e10 2E5 .25 3.e4 9L\n");
        send_text("0xg\n1e+\n.x\n");
        send_text("12");
        send_end();
        send_text("0x");
        send_end();
    endtask

    task automatic test_operators();
        send_text("()[]{};,> >= < <= = == != + += - -= * *= / /= % %= && || //\n");
        send_text("!\n&x\n|\n");
    endtask

    task automatic test_chars_illegal();
        send_text("'a' '\\'' 'ab'\n'\n");
        send_byte(8'h27, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("'\n");
        send_byte(8'hFF, 1'b0);
        send_text("\n");
        send_byte(8'h80, 1'b0);
        send_text("\n$\n");
        send_byte(8'h27, 1'b0);
        send_end();
    endtask

    task automatic test_directives();
        send_text("#define FOO 1 @@\n#include \"lib.h\" junk\n#\tinclude <x> \"n\"\n");
        send_text("#includes\n#\n#inc\n#include\n#include \"ab\r\n#include \"\"\n#dx\n");
        send_text("#include \"x");
        send_end();
        send_text("#incl");
        send_end();
        send_text("#define");
        send_end();
        send_end();
    endtask

    function automatic string pick_word(input string chars, input int n);
        string s;
        int j;
        s = "";
        repeat (n) begin
            j = $urandom_range(0, chars.len() - 1);
            s = {s, chars.substr(j, j)};
        end
        return s;
    endfunction

    // one random C-like fragment
    function automatic string random_fragment();
        string ops[25] = '{"(", ")", "[", "]", "{", "}", ";", ",", ">", ">=", "<", "<=", "=",
                           "==", "!=", "+", "+=", "-", "-=", "*", "*=", "/", "/=", "%", "%="};
        string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        string digits = "0123456789";
        string hexd = "0123456789abcdefABCDEF";
        case ($urandom_range(0, 17))
            0, 1: return kw_words[$urandom_range(0, 14)];
            2, 3: return {pick_word(letters, $urandom_range(1, 3)),
                          pick_word({letters, digits}, $urandom_range(0, 5))};
            4:  return {pick_word("123456789", 1), pick_word(digits, $urandom_range(0, 4)),
                        ($urandom_range(0, 3) == 0) ? string'("L") : string'("")};
            5:  return {"0x", pick_word(hexd, $urandom_range(0, 4))};
            6:  return {pick_word(digits, $urandom_range(0, 2)), ".",
                        pick_word(digits, $urandom_range(0, 3)),
                        ($urandom_range(0, 1) != 0) ? {"e", pick_word(digits,
                         $urandom_range(0, 2))} : string'("")};
            7:  return {"'", ($urandom_range(0, 2) == 0) ? string'("\\") : string'(""),
                        pick_word({letters, "'\\ "}, $urandom_range(1, 2)), "'"};
            8, 9: return ops[$urandom_range(0, 24)];
            10: return pick_word("!&|", $urandom_range(1, 2));
            11, 12: return pick_word(" \t\r", $urandom_range(1, 2));
            13: return "\n";
            14: return {"#define ", pick_word(letters, 3), " 1\n"};
            15: return {"#include \"", pick_word({letters, "."}, $urandom_range(0, 6)), "\"\n"};
            16: return {"#", pick_word(" incldefu", $urandom_range(0, 8)),
                        ($urandom_range(0, 1) != 0) ? string'("\"ab") : string'(""), "\n"};
            default: return pick_word("@$`?~\\\"", 1);
        endcase
    endfunction

    task automatic test_random(input int items);
        int sent;
        bit drained;
        sent = 0;
        drained = 1'b0;
        while (sent < items) begin
            if ($urandom_range(0, 99) == 0) idle_on = !idle_on;
            case ($urandom_range(0, 39))
                0: begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                    sent++;
                end
                1: begin
                    send_end();
                    sent++;
                end
                default: begin
                    string f;
                    f = random_fragment();
                    send_text(f);
                    sent += f.len();
                    if ($urandom_range(0, 1) != 0) begin
                        send_text(" ");
                        sent++;
                    end
                end
            endcase
            // hold the sender until the token queue has drained
            if (!drained && sent > items / 2) begin
                drained = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (expected_tokens.size() != 0) @(posedge aclk);
            end
        end
        idle_on = 1'b1;
    endtask

    // closing stretch with random idling off on both sides
    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (20) send_text("x1 = y+2;\n");
        send_end();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_words();
        test_numbers();
        test_operators();
        test_chars_illegal();
        test_directives();
        test_random(250);
        test_no_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("c_subset_lexer_tb OK");
        else
            $display("c_subset_lexer_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
